// ===== rtl/tun_pkg.sv =====
// Shared constants for the triangle unit normal pipeline.
`timescale 1ns / 1ps
package tun_pkg;
	localparam int OUT_W = 16;
endpackage

// ===== rtl/tun_sqrt_cell.sv =====
// One restoring square-root cell: resolves one root bit per stage.
`timescale 1ns / 1ps
module tun_sqrt_cell #(
	parameter int SW  = 72,
	parameter int LW  = 36,
	parameter int RW  = 38,
	parameter int SDW = 108,
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           v_i,
	input  logic [SW-1:0]  sum_i,
	input  logic [RW-1:0]  rem_i,
	input  logic [LW-1:0]  root_i,
	input  logic [SDW-1:0] side_i,
	output logic           v_o,
	output logic [SW-1:0]  sum_o,
	output logic [RW-1:0]  rem_o,
	output logic [LW-1:0]  root_o,
	output logic [SDW-1:0] side_o
);
	logic [RW+1:0] t;
	logic [RW+1:0] trial;
	logic          ge;
	logic [RW+1:0] diff;

	always_comb begin
		t     = {rem_i, sum_i[2*IDX+1 -: 2]};
		trial = (RW+2)'({root_i, 2'b01});
		ge    = t >= trial;
		diff  = t - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else begin
			v_o <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		sum_o  <= sum_i;
		side_o <= side_i;
		rem_o  <= ge ? diff[RW-1:0] : t[RW-1:0];
		root_o <= {root_i[LW-2:0], ge};
	end
endmodule

// ===== rtl/tun_div_cell.sv =====
// One restoring division cell: resolves one quotient bit of all three components.
`timescale 1ns / 1ps
module tun_div_cell #(
	parameter int LW    = 36,
	parameter int QW    = 15,
	parameter int SDW   = 3,
	parameter bit FIRST = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 v_i,
	input  logic [LW-1:0]        len_i,
	input  logic [2:0][LW:0]     rem_i,
	input  logic [2:0][QW-1:0]   q_i,
	input  logic [SDW-1:0]       side_i,
	output logic                 v_o,
	output logic [LW-1:0]        len_o,
	output logic [2:0][LW:0]     rem_o,
	output logic [2:0][QW-1:0]   q_o,
	output logic [SDW-1:0]       side_o
);
	logic [2:0][LW+1:0] r2;
	logic [2:0]         ge;
	logic [2:0][LW+1:0] diff;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			r2[k]   = FIRST ? (LW+2)'(rem_i[k]) : {rem_i[k], 1'b0};
			ge[k]   = r2[k] >= (LW+2)'(len_i);
			diff[k] = r2[k] - (LW+2)'(len_i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else begin
			v_o <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		len_o  <= len_i;
		side_o <= side_i;
		for (int k = 0; k < 3; k++) begin
			rem_o[k] <= ge[k] ? diff[k][LW:0] : r2[k][LW:0];
			q_o[k]   <= QW > 1 ? {q_i[k][QW-2:0], ge[k]} : QW'(ge[k]);
		end
	end
endmodule

// ===== rtl/triangle_unit_normal.sv =====
// Top level: triangle face normal, normalized to signed fixed point.
`timescale 1ns / 1ps
// channel  | ports                                      | transfer when
// ---------+--------------------------------------------+-------------------
// command  | start, busy, a_*, b_*, c_*                 | start && !busy
// result   | done, normal_x/y/z, degenerate             | done (one cycle)
// One triangle enters every cycle; busy is always low.
// Pipeline: edge, product, cross, square and sum stages, then the square-root
// cell chain (2*COORD_WIDTH+4 cells, one root bit each), then
// NORMAL_FRAC_BITS+1 division cells and one output stage.
// Reset clears only the valid bits; the receiver cannot stall.
module triangle_unit_normal #(
	parameter int COORD_WIDTH      = 16,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] a_x,
	input  logic signed [COORD_WIDTH-1:0] a_y,
	input  logic signed [COORD_WIDTH-1:0] a_z,
	input  logic signed [COORD_WIDTH-1:0] b_x,
	input  logic signed [COORD_WIDTH-1:0] b_y,
	input  logic signed [COORD_WIDTH-1:0] b_z,
	input  logic signed [COORD_WIDTH-1:0] c_x,
	input  logic signed [COORD_WIDTH-1:0] c_y,
	input  logic signed [COORD_WIDTH-1:0] c_z,
	output logic                          done,
	output logic signed [tun_pkg::OUT_W-1:0] normal_x,
	output logic signed [tun_pkg::OUT_W-1:0] normal_y,
	output logic signed [tun_pkg::OUT_W-1:0] normal_z,
	output logic                          degenerate
);
	localparam int EW   = COORD_WIDTH + 1;
	localparam int PW   = 2 * EW;
	localparam int NW   = PW + 1;
	localparam int MW   = NW;
	localparam int SW   = 2 * MW + 2;
	localparam int LW   = MW + 1;
	localparam int RW   = LW + 2;
	localparam int SDW  = 3 * MW + 3;
	localparam int QW   = NORMAL_FRAC_BITS + 1;
	localparam int ND   = QW;
	localparam int XW   = (QW > tun_pkg::OUT_W ? QW : tun_pkg::OUT_W) + 1;

	assign busy = 1'b0;

	// stage 1: edges
	logic              v_s1;
	logic signed [EW-1:0] e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;
	// stage 2: products
	logic              v_s2;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	// stage 3: cross product magnitudes and signs
	logic              v_s3;
	logic [2:0][MW-1:0] mag_s3;
	logic [2:0]        neg_s3;
	logic signed [NW-1:0] n0, n1, n2;
	// stage 4: squares
	logic              v_s4;
	logic [2:0][2*MW-1:0] sq_s4;
	logic [2:0][MW-1:0] mag_s4;
	logic [2:0]        neg_s4;
	// stage 5: sum
	logic              v_s5;
	logic [SW-1:0]     sum_s5;
	logic [2:0][MW-1:0] mag_s5;
	logic [2:0]        neg_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		n0 = NW'(p0_s2) - NW'(p1_s2);
		n1 = NW'(p2_s2) - NW'(p3_s2);
		n2 = NW'(p4_s2) - NW'(p5_s2);
	end

	always_ff @(posedge clk) begin
		e1x_s1 <= EW'(b_x) - EW'(a_x);
		e1y_s1 <= EW'(b_y) - EW'(a_y);
		e1z_s1 <= EW'(b_z) - EW'(a_z);
		e2x_s1 <= EW'(c_x) - EW'(a_x);
		e2y_s1 <= EW'(c_y) - EW'(a_y);
		e2z_s1 <= EW'(c_z) - EW'(a_z);

		p0_s2 <= PW'(e1y_s1) * PW'(e2z_s1);
		p1_s2 <= PW'(e1z_s1) * PW'(e2y_s1);
		p2_s2 <= PW'(e1z_s1) * PW'(e2x_s1);
		p3_s2 <= PW'(e1x_s1) * PW'(e2z_s1);
		p4_s2 <= PW'(e1x_s1) * PW'(e2y_s1);
		p5_s2 <= PW'(e1y_s1) * PW'(e2x_s1);

		neg_s3    <= {n2[NW-1], n1[NW-1], n0[NW-1]};
		mag_s3[0] <= n0[NW-1] ? MW'(-n0) : MW'(n0);
		mag_s3[1] <= n1[NW-1] ? MW'(-n1) : MW'(n1);
		mag_s3[2] <= n2[NW-1] ? MW'(-n2) : MW'(n2);

		for (int k = 0; k < 3; k++) begin
			sq_s4[k] <= (2*MW)'(mag_s3[k]) * (2*MW)'(mag_s3[k]);
		end
		mag_s4 <= mag_s3;
		neg_s4 <= neg_s3;

		sum_s5 <= SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]);
		mag_s5 <= mag_s4;
		neg_s5 <= neg_s4;
	end

	// square-root cell chain
	logic [LW:0]            sv;
	logic [LW:0][SW-1:0]    ssum;
	logic [LW:0][RW-1:0]    srem;
	logic [LW:0][LW-1:0]    sroot;
	logic [LW:0][SDW-1:0]   sside;

	assign sv[0]    = v_s5;
	assign ssum[0]  = sum_s5;
	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign sside[0] = {neg_s5, mag_s5};

	for (genvar j = 0; j < LW; j++) begin : g_sqrt
		tun_sqrt_cell #(
			.SW(SW), .LW(LW), .RW(RW), .SDW(SDW), .IDX(LW - 1 - j)
		) u_cell (
			.clk(clk), .arst_n(arst_n),
			.v_i(sv[j]), .sum_i(ssum[j]), .rem_i(srem[j]),
			.root_i(sroot[j]), .side_i(sside[j]),
			.v_o(sv[j+1]), .sum_o(ssum[j+1]), .rem_o(srem[j+1]),
			.root_o(sroot[j+1]), .side_o(sside[j+1])
		);
	end

	// division cell chain
	logic [ND:0]               dv;
	logic [ND:0][LW-1:0]       dlen;
	logic [ND:0][2:0][LW:0]    drem;
	logic [ND:0][2:0][QW-1:0]  dq;
	logic [ND:0][2:0]          dside;
	logic [2:0][MW-1:0]        smag;

	assign smag     = sside[LW][3*MW-1:0];
	assign dv[0]    = sv[LW];
	assign dlen[0]  = sroot[LW];
	assign dq[0]    = '0;
	assign dside[0] = sside[LW][SDW-1 -: 3];
	for (genvar k = 0; k < 3; k++) begin : g_drem
		assign drem[0][k] = (LW+1)'(smag[k]);
	end

	for (genvar j = 0; j < ND; j++) begin : g_div
		tun_div_cell #(
			.LW(LW), .QW(QW), .SDW(3), .FIRST(j == 0)
		) u_cell (
			.clk(clk), .arst_n(arst_n),
			.v_i(dv[j]), .len_i(dlen[j]), .rem_i(drem[j]),
			.q_i(dq[j]), .side_i(dside[j]),
			.v_o(dv[j+1]), .len_o(dlen[j+1]), .rem_o(drem[j+1]),
			.q_o(dq[j+1]), .side_o(dside[j+1])
		);
	end

	// output stage
	logic [2:0][XW-1:0] sq_out;
	logic               zero_len;

	always_comb begin
		zero_len = dlen[ND] == '0;
		for (int k = 0; k < 3; k++) begin
			sq_out[k] = dside[ND][k] ? XW'(-XW'(dq[ND][k])) : XW'(dq[ND][k]);
			if (zero_len) begin
				sq_out[k] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv[ND];
		end
	end

	always_ff @(posedge clk) begin
		normal_x   <= sq_out[0][tun_pkg::OUT_W-1:0];
		normal_y   <= sq_out[1][tun_pkg::OUT_W-1:0];
		normal_z   <= sq_out[2][tun_pkg::OUT_W-1:0];
		degenerate <= zero_len;
	end
endmodule
